// File: hdl/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

    // Sextet codes beyond the 64 alphabet values.
    localparam logic [6:0] SEXTET_PAD = 7'd64;
    localparam logic [6:0] SEXTET_BAD = 7'd65;

    // Number of result slots that one request can fill.
    localparam int unsigned MAX_RESULTS = 3;

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic       last;
        logic       done;
        logic       bad;
    } result_t;

    // All results that one request causes, with their count.
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] r;
        logic [1:0]                n;
    } bundle_t;

    // Map a character through the standard alphabet.
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [6:0] s;
        begin
            if (c >= 8'h41 && c <= 8'h5A) begin
                s = 7'(c - 8'h41);
            end
            else if (c >= 8'h61 && c <= 8'h7A) begin
                s = 7'(c - 8'h61 + 8'd26);
            end
            else if (c >= 8'h30 && c <= 8'h39) begin
                s = 7'(c - 8'h30 + 8'd52);
            end
            else if (c == 8'h2B) begin
                s = 7'd62;
            end
            else if (c == 8'h2F) begin
                s = 7'd63;
            end
            else if (c == 8'h3D) begin
                s = SEXTET_PAD;
            end
            else begin
                s = SEXTET_BAD;
            end
            return s;
        end
    endfunction

    // Build a result carrying a data byte.
    function automatic result_t data_result(input logic [7:0] b, input logic bad);
        result_t r;
        begin
            r = '0;
            r.data = b;
            r.data_valid = 1'b1;
            r.bad = bad;
            return r;
        end
    endfunction

    // Build a marker result with no data.
    function automatic result_t marker_result(input logic bad);
        result_t r;
        begin
            r = '0;
            r.bad = bad;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/b64d_decode.sv
`default_nettype none

module b64d_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        in_char,
    input  wire logic              end_of_text,
    output b64d_pkg::bundle_t      bundle
);
    import b64d_pkg::*;

    logic [17:0] group_reg, group_next;
    logic [1:0]  count_reg, count_next;
    logic        halted_reg, halted_next;

    logic [6:0]  s;
    logic        is_bad;
    logic        is_pad;
    logic [17:0] g_upd;
    logic [1:0]  c_upd;
    logic [1:0]  k;
    bundle_t     res;

    assign s      = map_char(in_char);
    assign is_bad = (s == SEXTET_BAD);
    assign is_pad = (s == SEXTET_PAD);

    // Results of the request and the next stream state.
    always_comb
    begin
        res        = '0;
        k          = 2'd0;
        g_upd      = group_reg;
        c_upd      = count_reg;
        group_next = group_reg;
        count_next = count_reg;
        halted_next = halted_reg;

        if (halted_reg) begin
            if (end_of_text) begin
                res.r[0]    = marker_result(1'b1);
                k           = 2'd1;
                halted_next = 1'b0;
                group_next  = '0;
                count_next  = '0;
            end
        end
        else if (is_bad) begin
            // Flush the partial group, flagged as bad.
            if (count_reg == 2'd2) begin
                res.r[0] = data_result(group_reg[11:4], 1'b1);
                k        = 2'd1;
            end
            else if (count_reg == 2'd3) begin
                res.r[0] = data_result(group_reg[17:10], 1'b1);
                res.r[1] = data_result(group_reg[9:2], 1'b1);
                k        = 2'd2;
            end
            if (k == 2'd0) begin
                res.r[0] = marker_result(1'b1);
                k        = 2'd1;
            end
            group_next  = '0;
            count_next  = '0;
            halted_next = !end_of_text;
        end
        else begin
            // Gather the sextet; a fourth one completes the group.
            if (!is_pad) begin
                if (count_reg == 2'd3) begin
                    res.r[0] = data_result(group_reg[17:10], 1'b0);
                    res.r[1] = data_result(group_reg[9:2], 1'b0);
                    res.r[2] = data_result({group_reg[1:0], s[5:0]}, 1'b0);
                    k        = 2'd3;
                    g_upd    = '0;
                    c_upd    = '0;
                end
                else begin
                    g_upd = {group_reg[11:0], s[5:0]};
                    c_upd = count_reg + 2'd1;
                end
            end
            group_next = g_upd;
            count_next = c_upd;

            // Stream end flushes what is left.
            if (end_of_text) begin
                if (c_upd == 2'd2) begin
                    res.r[0] = data_result(g_upd[11:4], 1'b0);
                    k        = 2'd1;
                end
                else if (c_upd == 2'd3) begin
                    res.r[0] = data_result(g_upd[17:10], 1'b0);
                    res.r[1] = data_result(g_upd[9:2], 1'b0);
                    k        = 2'd2;
                end
                if (k == 2'd0) begin
                    res.r[0] = marker_result(1'b0);
                    k        = 2'd1;
                end
                group_next = '0;
                count_next = '0;
            end
        end

        // Mark the last result of the request, and of the stream.
        if (k != 2'd0) begin
            res.r[k - 2'd1].last = 1'b1;
            res.r[k - 2'd1].done = end_of_text;
        end
        res.n  = k;
        bundle = res;
    end

    // Stream state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            group_reg  <= '0;
            count_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else if (accept) begin
            group_reg  <= group_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
        end
    end

    // A halted stream holds no sextets.
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (count_reg == 2'd0))
        else $error("halted with sextets held");

    // A full group is never kept: the fourth sextet empties it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !halted_reg && !is_bad && !is_pad && count_reg == 2'd3)
        |=> (count_reg == 2'd0))
        else $error("complete group not emptied");

    // Stream end always leaves a clean state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_text) |=> (!halted_reg && count_reg == 2'd0))
        else $error("state not cleared at stream end");

endmodule

`default_nettype wire

// File: hdl/b64d_serializer.sv
`default_nettype none

module b64d_serializer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire b64d_pkg::bundle_t bundle,
    output logic                   free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output b64d_pkg::result_t      result
);
    import b64d_pkg::*;

    bundle_t    bundle_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       take;
    logic       last_take;

    assign take      = valid_reg && out_ready;
    assign last_take = take && ((idx_reg + 2'd1) == bundle_reg.n);
    assign free      = !valid_reg || last_take;
    assign out_valid = valid_reg;
    assign result    = bundle_reg.r[idx_reg];

    // Result buffer: one slot goes out per cycle while out_ready is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load && bundle.n != 2'd0) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (last_take) begin
            valid_reg <= 1'b0;
        end
        else if (take) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && bundle.n != 2'd0) begin
            bundle_reg <= bundle;
        end
    end

    // The slot shown always lies within the bundle.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg < bundle_reg.n))
        else $error("slot index beyond bundle");

    // An empty buffer takes a new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> free)
        else $error("empty buffer not free");

    // A taken slot that is not the last moves to the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last_take) |=> (valid_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("slot did not advance");

    // A stalled result holds its slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(idx_reg)))
        else $error("stalled slot moved");

endmodule

`default_nettype wire

// File: hdl/base64_stream_decoder.sv
`default_nettype none

// Latency: the first result of a request appears the cycle after it is accepted.
// Throughput: one request per cycle while each gives at most one result and the
// output is not stalled; a request that gives k results holds the output buffer
// until its last result is taken, one result per cycle while out_ready is high.
// Reset (rst_n low, asynchronous) clears the stream state and empties the buffer.
module base64_stream_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_char,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            run_last,
    output logic            stream_done,
    output logic            bad_char
);
    import b64d_pkg::*;

    bundle_t bundle;
    result_t result;
    logic    free;
    logic    accept;

    assign in_ready = free;
    assign accept   = in_valid && free;

    // Character decode and stream state.
    b64d_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_char     (in_char),
        .end_of_text (end_of_text),
        .bundle      (bundle)
    );

    // Result buffer toward the output channel.
    b64d_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .bundle    (bundle),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign out_byte    = result.data;
    assign byte_valid  = result.data_valid;
    assign run_last    = result.last;
    assign stream_done = result.done;
    assign bad_char    = result.bad;

endmodule

`default_nettype wire
